// ----- hdl/nsv_pkg.sv -----
// nsv_pkg: types and constants shared by the network settings validator
// used by nsv_front, nsv_queue, nsv_check and network_settings_validator
package nsv_pkg;

    localparam logic KIND_NAME_BYTE = 1'b0;
    localparam logic KIND_CLOSE     = 1'b1;

    localparam logic [7:0] MODE_DHCP   = 8'd0;
    localparam logic [7:0] MODE_STATIC = 8'd1;

    localparam logic [7:0] OCTET_LOOPBACK = 8'd127;
    localparam logic [7:0] OCTET_CLASS_D  = 8'd224;
    localparam logic [7:0] CHAR_HYPHEN    = 8'h2d;

    // smallest inverted mask that still leaves a usable host range
    localparam logic [31:0] MIN_HOST_BITS_INV = 32'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REASON_OK     = 2'd0,
        REASON_NAME   = 2'd1,
        REASON_DHCP   = 2'd2,
        REASON_STATIC = 2'd3
    } reason_t;

    // one closing record as classified by the front part
    typedef struct packed {
        logic        name_ok;
        logic [7:0]  mode;
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] dns;
    } record_t;

    // queue status: full drives s_ready at the top level, not_empty feeds the back part
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// ----- hdl/nsv_front.sv -----
// nsv_front: accepts input transfers, tracks hostname flags and forms records
// depends on nsv_pkg
module nsv_front #(
    parameter int NAME_BUFFER_BYTES = 64,
    parameter int MAX_LABEL_CHARS   = 63
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   kind,
    input  logic [7:0]             name_byte,
    input  logic [7:0]             record_mode,
    input  logic [31:0]            host_address,
    input  logic [31:0]            subnet_mask,
    input  logic [31:0]            gateway_address,
    input  logic [31:0]            dns_server,
    output logic                   push,
    output nsv_pkg::record_t       push_data
);

    localparam int LEN_W = $clog2(NAME_BUFFER_BYTES + 1);

    logic [LEN_W-1:0] name_length_reg, name_length_next;
    logic name_terminated_reg, name_terminated_next;
    logic first_char_ok_reg, first_char_ok_next;
    logic last_char_alnum_reg, last_char_alnum_next;
    logic bad_char_seen_reg, bad_char_seen_next;

    logic byte_alnum;
    logic buffer_full;
    logic name_ok;

    assign byte_alnum = name_byte inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]};

    assign buffer_full = int'(name_length_reg) >= NAME_BUFFER_BYTES;

    assign name_ok = name_terminated_reg && (name_length_reg != '0) &&
                     (int'(name_length_reg) <= MAX_LABEL_CHARS) &&
                     first_char_ok_reg && last_char_alnum_reg && !bad_char_seen_reg;

    always_comb begin
        name_length_next     = name_length_reg;
        name_terminated_next = name_terminated_reg;
        first_char_ok_next   = first_char_ok_reg;
        last_char_alnum_next = last_char_alnum_reg;
        bad_char_seen_next   = bad_char_seen_reg;
        if (accept && kind == nsv_pkg::KIND_CLOSE) begin
            name_length_next     = '0;
            name_terminated_next = 1'b0;
            first_char_ok_next   = 1'b0;
            last_char_alnum_next = 1'b0;
            bad_char_seen_next   = 1'b0;
        end else if (accept && !name_terminated_reg && !buffer_full) begin
            if (name_byte == 8'd0) begin
                name_terminated_next = 1'b1;
            end else begin
                if (name_length_reg == '0) begin
                    first_char_ok_next = byte_alnum;
                end
                last_char_alnum_next = byte_alnum;
                if (!byte_alnum && name_byte != nsv_pkg::CHAR_HYPHEN) begin
                    bad_char_seen_next = 1'b1;
                end
                name_length_next = name_length_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_length_reg     <= '0;
            name_terminated_reg <= 1'b0;
            first_char_ok_reg   <= 1'b0;
            last_char_alnum_reg <= 1'b0;
            bad_char_seen_reg   <= 1'b0;
        end else begin
            name_length_reg     <= name_length_next;
            name_terminated_reg <= name_terminated_next;
            first_char_ok_reg   <= first_char_ok_next;
            last_char_alnum_reg <= last_char_alnum_next;
            bad_char_seen_reg   <= bad_char_seen_next;
        end
    end

    assign push              = accept && kind == nsv_pkg::KIND_CLOSE;
    assign push_data.name_ok = name_ok;
    assign push_data.mode    = record_mode;
    assign push_data.host    = host_address;
    assign push_data.mask    = subnet_mask;
    assign push_data.gateway = gateway_address;
    assign push_data.dns     = dns_server;

endmodule

// ----- hdl/nsv_queue.sv -----
// nsv_queue: short record queue between the front and back parts
// depends on nsv_pkg
module nsv_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  nsv_pkg::record_t        push_data,
    input  logic                    pop,
    output nsv_pkg::record_t        pop_data,
    output nsv_pkg::queue_status_t  status
);

    localparam int PTR_W = nsv_pkg::QUEUE_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    nsv_pkg::record_t entry_reg [nsv_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data         = entry_reg[rd_ptr_reg];
    assign status.full      = count_reg == CNT_W'(nsv_pkg::QUEUE_DEPTH);
    assign status.not_empty = count_reg != '0;

endmodule

// ----- hdl/nsv_check.sv -----
// nsv_check: runs the mode and address checks and holds the result register
// depends on nsv_pkg
module nsv_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rec_valid,
    input  nsv_pkg::record_t  rec,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_valid_res,
    output logic [1:0]        m_reason_code
);

    function automatic logic is_unicast(input logic [31:0] a);
        logic [7:0] top;
        top = a[31:24];
        return a != 32'd0 && a != 32'hffff_ffff && top != 8'd0 &&
               top != nsv_pkg::OCTET_LOOPBACK && top < nsv_pkg::OCTET_CLASS_D;
    endfunction

    logic [31:0] inv;
    logic [31:0] net;
    logic [31:0] bcast;
    logic        mask_ok;
    logic        place_ok;
    logic        static_ok;
    nsv_pkg::reason_t reason;

    logic             m_valid_reg, m_valid_next;
    nsv_pkg::reason_t reason_reg;

    always_comb begin
        inv     = ~rec.mask;
        net     = rec.host & rec.mask;
        bcast   = net | inv;
        // contiguous mask with at least two host bits
        mask_ok = rec.mask != 32'd0 && inv >= nsv_pkg::MIN_HOST_BITS_INV &&
                  (inv & (inv + 32'd1)) == 32'd0;
        place_ok = rec.host != net && rec.host != bcast &&
                   (rec.gateway & rec.mask) == net && rec.gateway != net &&
                   rec.gateway != bcast && rec.gateway != rec.host;
        static_ok = is_unicast(rec.host) && is_unicast(rec.gateway) && mask_ok &&
                    place_ok && (rec.dns == 32'd0 || is_unicast(rec.dns));
    end

    always_comb begin
        if (!rec.name_ok) begin
            reason = nsv_pkg::REASON_NAME;
        end else begin
            case (rec.mode)
                nsv_pkg::MODE_DHCP: begin
                    reason = ((rec.host | rec.mask | rec.gateway | rec.dns) != 32'd0) ?
                             nsv_pkg::REASON_DHCP : nsv_pkg::REASON_OK;
                end
                nsv_pkg::MODE_STATIC: begin
                    reason = static_ok ? nsv_pkg::REASON_OK : nsv_pkg::REASON_STATIC;
                end
                default: begin
                    reason = nsv_pkg::REASON_STATIC;
                end
            endcase
        end
    end

    // take a record when the result register is empty or being drained
    assign pop = rec_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            reason_reg <= reason;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_valid_res   = reason_reg == nsv_pkg::REASON_OK;
    assign m_reason_code = reason_reg;

endmodule

// ----- hdl/network_settings_validator.sv -----
// network_settings_validator: top level of the network settings record checker
// depends on nsv_pkg, nsv_front, nsv_queue and nsv_check
//
// Takes one transfer per clock: hostname bytes update a length counter and a
// few flags in the front part, and a closing transfer writes the classified
// record into a four-entry queue. The back part pops one record per cycle
// while the result register is empty or being drained, runs the mode and
// address compares on the queue entry and loads the result register.
// The input stalls only when the queue is full, i.e. after four closing
// transfers pile up behind a result that m_ready has not taken.
module network_settings_validator #(
    parameter int NAME_BUFFER_BYTES = 64,
    parameter int MAX_LABEL_CHARS   = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_name_byte,
    input  logic [7:0]  s_record_mode,
    input  logic [31:0] s_host_address,
    input  logic [31:0] s_subnet_mask,
    input  logic [31:0] s_gateway_address,
    input  logic [31:0] s_dns_server,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [1:0]  m_reason_code
);

    logic                   accept;
    logic                   push;
    logic                   pop;
    nsv_pkg::record_t       push_data;
    nsv_pkg::record_t       pop_data;
    nsv_pkg::queue_status_t q_status;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    nsv_front #(
        .NAME_BUFFER_BYTES(NAME_BUFFER_BYTES),
        .MAX_LABEL_CHARS  (MAX_LABEL_CHARS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .kind           (s_kind),
        .name_byte      (s_name_byte),
        .record_mode    (s_record_mode),
        .host_address   (s_host_address),
        .subnet_mask    (s_subnet_mask),
        .gateway_address(s_gateway_address),
        .dns_server     (s_dns_server),
        .push           (push),
        .push_data      (push_data)
    );

    nsv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .status   (q_status)
    );

    nsv_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rec_valid    (q_status.not_empty),
        .rec          (pop_data),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_valid_res  (m_valid_res),
        .m_reason_code(m_reason_code)
    );

endmodule

// ----- tb/sv/network_settings_validator_tb.sv -----
// network_settings_validator_tb: self-checking bench for the network settings record checker
// needs nsv_pkg and network_settings_validator; predicts each verdict from the hostname
// bytes and closing record it has sent, then checks every result transfer in order
module network_settings_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_BUFFER_BYTES = 64;
    localparam int MAX_LABEL_CHARS   = 63;
    localparam int HOLD_CYCLES       = 300;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic [7:0]  mode;
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] dns;
        logic [7:0]  send_gap_pct;
        logic [7:0]  recv_gap_pct;
        logic        hold_after;
    } setting_item_t;

    typedef struct packed {
        logic             ok;
        nsv_pkg::reason_t reason;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [1:0]  m_reason_code;
    setting_item_t offered = '0;

    setting_item_t pending_items[$];
    verdict_t      expected_verdicts[$];
    int            error_count = 0;
    int            hold_left = 0;
    int            recv_gap_pct = 0;
    int            phase_send_gap = 0;
    int            phase_recv_gap = 0;
    bit            hold_armed = 1'b0;

    // hostname state of the record being collected
    int unsigned name_len = 0;
    bit          name_done = 1'b0;
    bit          first_alnum = 1'b0;
    bit          last_alnum = 1'b0;
    bit          bad_char = 1'b0;

    network_settings_validator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (offered.kind),
        .s_name_byte       (offered.name_byte),
        .s_record_mode     (offered.mode),
        .s_host_address    (offered.host),
        .s_subnet_mask     (offered.mask),
        .s_gateway_address (offered.gateway),
        .s_dns_server      (offered.dns),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_reason_code     (m_reason_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_alnum_char(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], ["0":"9"]};
    endfunction

    function automatic bit is_unicast_addr(logic [31:0] a);
        return a != '0 && a != '1 && a[31:24] != 8'd0 &&
            a[31:24] != nsv_pkg::OCTET_LOOPBACK && a[31:24] < nsv_pkg::OCTET_CLASS_D;
    endfunction

    function automatic bit static_addresses_ok(logic [31:0] host, logic [31:0] mask,
                                               logic [31:0] gw, logic [31:0] dns);
        logic [31:0] inv;
        logic [31:0] net;
        logic [31:0] bcast;
        inv = ~mask;
        if (!is_unicast_addr(host) || !is_unicast_addr(gw) || mask == '0 ||
            inv < nsv_pkg::MIN_HOST_BITS_INV || (inv & (inv + 32'd1)) != '0)
            return 1'b0;
        net = host & mask;
        bcast = net | inv;
        if (host == net || host == bcast || (gw & mask) != net || gw == net ||
            gw == bcast || gw == host)
            return 1'b0;
        return dns == '0 || is_unicast_addr(dns);
    endfunction

    // update the hostname state, or produce the verdict on a closing transfer
    function automatic void predict_setting_item(setting_item_t it);
        bit       an;
        bit       name_ok;
        verdict_t v;
        if (it.kind == nsv_pkg::KIND_NAME_BYTE) begin
            if (!name_done && name_len < NAME_BUFFER_BYTES) begin
                if (it.name_byte == 8'h00) begin
                    name_done = 1'b1;
                end else begin
                    an = is_alnum_char(it.name_byte);
                    if (name_len == 0)
                        first_alnum = an;
                    last_alnum = an;
                    if (!an && it.name_byte != nsv_pkg::CHAR_HYPHEN)
                        bad_char = 1'b1;
                    name_len++;
                end
            end
            return;
        end
        name_ok = name_done && name_len >= 1 && name_len <= MAX_LABEL_CHARS &&
            first_alnum && last_alnum && !bad_char;
        if (!name_ok)
            v.reason = nsv_pkg::REASON_NAME;
        else if (it.mode == nsv_pkg::MODE_DHCP)
            v.reason = ((it.host | it.mask | it.gateway | it.dns) != '0) ?
                nsv_pkg::REASON_DHCP : nsv_pkg::REASON_OK;
        else if (it.mode == nsv_pkg::MODE_STATIC)
            v.reason = static_addresses_ok(it.host, it.mask, it.gateway, it.dns) ?
                nsv_pkg::REASON_OK : nsv_pkg::REASON_STATIC;
        else
            v.reason = nsv_pkg::REASON_STATIC;
        v.ok = (v.reason == nsv_pkg::REASON_OK);
        expected_verdicts.push_back(v);
        name_len = 0;
        name_done = 1'b0;
        first_alnum = 1'b0;
        last_alnum = 1'b0;
        bad_char = 1'b0;
    endfunction

    function automatic void queue_item(logic kind, logic [7:0] name_byte, logic [7:0] mode,
                                       logic [31:0] host, logic [31:0] mask,
                                       logic [31:0] gw, logic [31:0] dns);
        setting_item_t it;
        it.kind = kind;
        it.name_byte = name_byte;
        it.mode = mode;
        it.host = host;
        it.mask = mask;
        it.gateway = gw;
        it.dns = dns;
        it.send_gap_pct = 8'(phase_send_gap);
        it.recv_gap_pct = 8'(phase_recv_gap);
        it.hold_after = hold_armed;
        hold_armed = 1'b0;
        pending_items.push_back(it);
    endfunction

    // fields that do not belong to the kind carry random junk
    function automatic void push_name_byte(logic [7:0] b);
        queue_item(nsv_pkg::KIND_NAME_BYTE, b, 8'($urandom), $urandom, $urandom, $urandom,
                   $urandom);
    endfunction

    function automatic void push_close(logic [7:0] mode, logic [31:0] host, logic [31:0] mask,
                                       logic [31:0] gw, logic [31:0] dns);
        queue_item(nsv_pkg::KIND_CLOSE, 8'($urandom), mode, host, mask, gw, dns);
    endfunction

    function automatic void push_name(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_name_byte(s[i]);
        push_name_byte(8'h00);
    endfunction

    function automatic logic [7:0] alnum_char();
        int r;
        r = $urandom_range(61);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(19))
            0: return 8'($urandom_range(255, 1));
            1: return nsv_pkg::CHAR_HYPHEN;
            default: return alnum_char();
        endcase
    endfunction

    function automatic logic [7:0] unicast_top();
        logic [7:0] t;
        t = 8'($urandom_range(223, 1));
        if (t == nsv_pkg::OCTET_LOOPBACK)
            t = 8'd126;
        return t;
    endfunction

    function automatic logic [7:0] bad_top();
        case ($urandom_range(2))
            0: return 8'd0;
            1: return nsv_pkg::OCTET_LOOPBACK;
            default: return 8'($urandom_range(255, 224));
        endcase
    endfunction

    // mostly well-formed records with random content, some of them broken on purpose
    function automatic void queue_random_record(bit short_name);
        int          name_len_r;
        int          sel;
        int          prefix;
        int          i;
        logic [7:0]  b;
        logic [7:0]  mode;
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [31:0] dns;
        logic [31:0] inv;
        logic [31:0] net;
        logic [31:0] hb;
        sel = $urandom_range(99);
        if (short_name)
            name_len_r = $urandom_range(4, 1);
        else if (sel < 8)
            name_len_r = $urandom_range(70, 56);
        else if (sel < 12)
            name_len_r = 0;
        else
            name_len_r = $urandom_range(12, 1);
        for (i = 0; i < name_len_r; i++) begin
            b = name_char();
            if ((i == 0 || i == name_len_r - 1) && $urandom_range(9) != 0)
                b = alnum_char();
            push_name_byte(b);
        end
        if ($urandom_range(19) != 0) begin
            push_name_byte(8'h00);
            repeat ($urandom_range(2)) push_name_byte(8'($urandom));
        end
        host = '0;
        mask = '0;
        gw = '0;
        dns = '0;
        sel = $urandom_range(9);
        if (sel < 4) begin
            mode = nsv_pkg::MODE_DHCP;
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0: host = $urandom | 32'd1;
                    1: mask = $urandom | 32'd1;
                    2: gw = $urandom | 32'd1;
                    default: dns = $urandom | 32'd1;
                endcase
            end
        end else if (sel < 9) begin
            mode = nsv_pkg::MODE_STATIC;
            prefix = ($urandom_range(4) == 0) ? $urandom_range(30, 1) : $urandom_range(30, 8);
            mask = 32'hFFFF_FFFF << (32 - prefix);
            inv = ~mask;
            net = {unicast_top(), 24'($urandom)} & mask;
            hb = $urandom & inv;
            if (hb == '0)
                hb = 32'd1;
            else if (hb == inv)
                hb = inv - 32'd1;
            host = net | hb;
            hb = $urandom & inv;
            if (hb == '0)
                hb = 32'd1;
            else if (hb == inv)
                hb = inv - 32'd1;
            gw = net | hb;
            if (gw == host)
                gw = net | (((host & inv) == 32'd1) ? 32'd2 : 32'd1);
            dns = ($urandom_range(1) != 0) ? 32'd0 : {unicast_top(), 24'($urandom)};
            if ($urandom_range(9) < 4) begin
                case ($urandom_range(9))
                    0: host = net;
                    1: host = net | inv;
                    2: gw = host;
                    3: gw = gw ^ (32'h8000_0000 >> $urandom_range(prefix - 1));
                    4: mask = mask ^ (32'd1 << $urandom_range(31));
                    5: begin
                        case ($urandom_range(2))
                            0: mask = '0;
                            1: mask = '1;
                            default: mask = 32'hFFFF_FFFE;
                        endcase
                    end
                    6: dns = {8'($urandom_range(255, 224)), 24'($urandom)};
                    7: host[31:24] = bad_top();
                    8: gw[31:24] = bad_top();
                    default: begin
                        host = $urandom;
                        mask = $urandom;
                        gw = $urandom;
                        dns = $urandom;
                    end
                endcase
            end
        end else begin
            mode = 8'($urandom_range(255, 2));
            host = $urandom;
            mask = $urandom;
            gw = $urandom;
            dns = $urandom;
        end
        push_close(mode, host, mask, gw, dns);
    endfunction

    // sender: offers queued items, idling at the rate tagged on each one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_setting_item(offered);
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                    $urandom_range(99) >= pending_items[0].send_gap_pct) begin
                    offered <= pending_items[0];
                    recv_gap_pct <= pending_items[0].recv_gap_pct;
                    void'(pending_items.pop_front());
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started by a tagged transfer
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (s_valid && s_ready && offered.hold_after)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin : result_monitor
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transfer: valid_res %0d reason_code %0d",
                           m_valid_res, m_reason_code);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_valid_res !== want.ok) begin
                        $error("valid_res: expected %0d, actual %0d", want.ok, m_valid_res);
                        error_count++;
                    end
                    if (m_reason_code !== want.reason) begin
                        $error("reason_code: expected %0d, actual %0d", want.reason,
                               m_reason_code);
                        error_count++;
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    initial begin
        int ph;
        phase_send_gap = 10;
        phase_recv_gap = 79;

        // trailing byte after the terminator is ignored
        push_name("a");
        push_name_byte("_");
        push_close(nsv_pkg::MODE_DHCP, '0, '0, '0, '0);
        push_name("Z9");
        push_close(nsv_pkg::MODE_STATIC, 32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101,
                   32'h0808_0808);
        // no terminator at all
        push_close(nsv_pkg::MODE_DHCP, '0, '0, '0, '0);
        push_name("");
        push_close(nsv_pkg::MODE_DHCP, '0, '0, '0, '0);
        push_name("a-b");
        push_close(8'hFF, '1, '1, '1, '1);
        push_name("a_");
        push_close(nsv_pkg::MODE_DHCP, '0, '0, '0, '0);
        push_name("b");
        push_close(nsv_pkg::MODE_DHCP, '0, '0, '0, 32'h0808_0808);
        // mask leaves a single host bit
        push_name("c");
        push_close(nsv_pkg::MODE_STATIC, 32'h0A00_0001, 32'hFFFF_FFFE, 32'h0A00_0000, '0);

        // receiver stops for a long while so the record queue fills and s_ready drops
        phase_send_gap = 0;
        hold_armed = 1'b1;
        repeat (12) queue_random_record(1'b1);

        for (ph = 0; ph < 3; ph++) begin
            phase_send_gap = (ph == 0) ? 10 : (ph == 1) ? 79 : 0;
            phase_recv_gap = (ph == 0) ? 79 : (ph == 1) ? 10 : 0;
            while (pending_items.size() < (ph + 1) * 340) begin
                if ($urandom_range(9) == 0)
                    queue_item(1'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom,
                               $urandom, $urandom);
                else
                    queue_random_record(1'b0);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("network_settings_validator_tb: done, clean");
        else
            $display("network_settings_validator_tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("network_settings_validator_tb: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nsv_pkg.sv
hdl/nsv_front.sv
hdl/nsv_queue.sv
hdl/nsv_check.sv
hdl/network_settings_validator.sv
tb/sv/network_settings_validator_tb.sv
